FILE: sv/soft_ellipse_pixel_shader_core_macros.svh
// Assertion helpers shared by the shader RTL.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef SOFT_ELLIPSE_PIXEL_SHADER_CORE_MACROS_SVH
`define SOFT_ELLIPSE_PIXEL_SHADER_CORE_MACROS_SVH

// Same-cycle implication.
`define SEP_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SEP_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/sep_pkg.sv
`default_nettype none

package sep_pkg;

   localparam int COORD_BITS = 12;
   // signed offset in Q13.4 and its magnitude in Q12.4
   localparam int OFS_W = COORD_BITS + 5;
   localparam int ABS_W = COORD_BITS + 4;

   // distance divider: (num << FRAC_SHIFT) / den
   localparam int NUM_W       = 35;
   localparam int FRAC_SHIFT  = 28;
   localparam int DIV1_DEN_W  = 32;
   localparam int DIV1_QUOT_W = 46;
   localparam int ROOT_W      = DIV1_QUOT_W / 2;
   // rim divider: over * rmax / softness, 14 fraction bits
   localparam int DIV2_DEN_W  = 8;
   localparam int DIV2_QUOT_W = 14;

   localparam logic [14:0] ONE_Q14     = 15'd16384;
   localparam logic [16:0] ONE_Q16     = 17'd65536;
   localparam logic [12:0] INNER_SLOPE = 13'd7864;
   localparam logic [15:0] RIM_PEAK    = 16'd58982;
   localparam logic [15:0] SMOOTH_3    = 16'd49152;
   localparam logic [16:0] ALPHA_MIN   = 17'd327;

   localparam logic       CSR_EDGE_SOFTNESS = 1'b0;
   localparam logic       CSR_FRAME_FADE    = 1'b1;
   localparam logic [7:0] EDGE_SOFTNESS_RST = 8'd24;
   localparam logic [8:0] FRAME_FADE_RST    = 9'd256;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
      logic [7:0]            radius_x;
      logic [7:0]            radius_y;
      logic [8:0]            opacity;
      logic [8:0]            color_red;
      logic [8:0]            color_green;
      logic [8:0]            color_blue;
      logic [23:0]           current_rgb;
   } sep_req_type;

   typedef struct packed {
      logic [23:0] new_rgb;
      logic        pixel_written;
   } sep_rsp_type;

   // data that rides along the divider and root pipelines
   typedef struct packed {
      logic        far;
      logic        in_core;
      logic        rim;
      logic [16:0] alpha;
      logic [7:0]  rmax;
      logic [8:0]  opacity;
      logic [8:0]  color_red;
      logic [8:0]  color_green;
      logic [8:0]  color_blue;
      logic [23:0] current_rgb;
   } sep_side_type;

endpackage

`default_nettype wire

FILE: sv/sep_div_pipe.sv
`default_nettype none

// Restoring divider, one quotient bit per stage.
// Requires dividend >> QUOT_W < divisor.
module sep_div_pipe import sep_pkg::*; #(
   parameter int DEN_W  = 32,
   parameter int QUOT_W = 46
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [DEN_W+QUOT_W-1:0] in_dividend,
   input  logic [DEN_W-1:0]        in_divisor,
   input  sep_side_type            in_side,
   output logic                    out_valid,
   output logic [QUOT_W-1:0]       out_quot,
   output sep_side_type            out_side
);

   logic               valid_ff [QUOT_W];
   logic [DEN_W-1:0]   rem_ff   [QUOT_W];
   logic [QUOT_W-1:0]  bits_ff  [QUOT_W];
   logic [DEN_W-1:0]   div_ff   [QUOT_W];
   sep_side_type       side_ff  [QUOT_W];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_step
      logic              v_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [DEN_W-1:0]  div_prev;
      logic [QUOT_W-1:0] bits_prev;
      sep_side_type      side_prev;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [QUOT_W-1:0] bits_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = in_dividend[DEN_W+QUOT_W-1:QUOT_W];
         assign bits_prev = in_dividend[QUOT_W-1:0];
         assign div_prev  = in_divisor;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign bits_prev = bits_ff[k-1];
         assign div_prev  = div_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign trial   = {rem_prev, bits_prev[QUOT_W-1]};
      assign ge      = trial >= {1'b0, div_prev};
      assign diff    = trial - {1'b0, div_prev};
      assign rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign bits_in = {bits_prev[QUOT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= v_prev;
         end
         rem_ff[k]  <= rem_in;
         bits_ff[k] <= bits_in;
         div_ff[k]  <= div_prev;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign out_quot  = bits_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

`default_nettype wire

FILE: sv/sep_sqrt_pipe.sv
`default_nettype none

// Integer square root, one root bit per stage (floor).
module sep_sqrt_pipe import sep_pkg::*; #(
   parameter int RW = 23
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2*RW-1:0]   in_radicand,
   input  sep_side_type      in_side,
   output logic              out_valid,
   output logic [RW-1:0]     out_root,
   output sep_side_type      out_side
);

   logic             valid_ff [RW];
   logic [RW:0]      rem_ff   [RW];
   logic [RW-1:0]    root_ff  [RW];
   logic [2*RW-1:0]  rad_ff   [RW];
   sep_side_type     side_ff  [RW];

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic            v_prev;
      logic [RW:0]     rem_prev;
      logic [RW-1:0]   root_prev;
      logic [2*RW-1:0] rad_prev;
      sep_side_type    side_prev;
      logic [RW+2:0]   rem_sh;
      logic [RW+2:0]   trial;
      logic [RW+2:0]   diff;
      logic            ge;
      logic [RW:0]     rem_in;
      logic [RW-1:0]   root_in;
      logic [2*RW-1:0] rad_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_radicand;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign rem_sh  = {rem_prev, rad_prev[2*RW-1:2*RW-2]};
      assign trial   = {1'b0, root_prev, 2'b01};
      assign ge      = rem_sh >= trial;
      assign diff    = rem_sh - trial;
      assign rem_in  = ge ? diff[RW:0] : rem_sh[RW:0];
      assign root_in = {root_prev[RW-2:0], ge};
      assign rad_in  = {rad_prev[2*RW-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= v_prev;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

`default_nettype wire

FILE: sv/soft_ellipse_pixel_shader_core.sv
// Channel   Handshake                     Payload
// req       start / busy (busy always 0)   req_data  (sep_req_type)
// rsp       rsp_strobe, one cycle          rsp_data  (sep_rsp_type)
// csr       csr_valid / csr_ready (=1)     csr_index, csr_data
//
// One pixel item per clock, every clock; busy never rises.
// The pipeline holds 46 stages of the distance divider, 23 of the
// square root, 14 of the rim divider and 13 arithmetic stages.
// Synchronous active-high reset clears all valid bits and sets the two CSRs to their reset values.
// No stalls: the receiver takes each result in its strobe cycle.
`default_nettype none
`include "soft_ellipse_pixel_shader_core_macros.svh"

module soft_ellipse_pixel_shader_core import sep_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  sep_req_type req_data,
   output logic        rsp_strobe,
   output sep_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);

   localparam int LATENCY = 4 + DIV1_QUOT_W + ROOT_W + 2 + DIV2_QUOT_W + 7;
   localparam int PAD1_W  = DIV1_DEN_W + DIV1_QUOT_W - NUM_W - FRAC_SHIFT;

   // ------------------------------------------------------------------
   // CSRs; not enforced here, the user writes them only while the pipeline is empty
   // ------------------------------------------------------------------
   logic [7:0] soft_ff;
   logic [8:0] fade_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         soft_ff <= EDGE_SOFTNESS_RST;
         fade_ff <= FRAME_FADE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EDGE_SOFTNESS: soft_ff <= csr_data[7:0];
            CSR_FRAME_FADE:    fade_ff <= csr_data;
            default:           ;
         endcase
      end
   end

   wire accept = start && !busy;

   // ------------------------------------------------------------------
   // S1: Q13.4 offsets (d*16 + 8), magnitudes, far-box reject
   // ------------------------------------------------------------------
   logic [COORD_BITS:0] dif_x, dif_y;
   logic [OFS_W-1:0]    ofs_x, ofs_y, neg_x, neg_y;
   logic [ABS_W-1:0]    ax, ay;
   logic [7:0]          rx_fix, ry_fix;
   logic [8:0]          lim_x, lim_y;
   logic                far;
   sep_side_type        s1_side_in;

   assign dif_x  = {1'b0, req_data.pixel_x} - {1'b0, req_data.center_x};
   assign dif_y  = {1'b0, req_data.pixel_y} - {1'b0, req_data.center_y};
   assign ofs_x  = {dif_x, 4'b1000};
   assign ofs_y  = {dif_y, 4'b1000};
   assign neg_x  = -ofs_x;
   assign neg_y  = -ofs_y;
   assign ax     = ofs_x[OFS_W-1] ? neg_x[ABS_W-1:0] : ofs_x[ABS_W-1:0];
   assign ay     = ofs_y[OFS_W-1] ? neg_y[ABS_W-1:0] : ofs_y[ABS_W-1:0];
   // zero radius counts as one LSB
   assign rx_fix = (req_data.radius_x == 8'd0) ? 8'd1 : req_data.radius_x;
   assign ry_fix = (req_data.radius_y == 8'd0) ? 8'd1 : req_data.radius_y;
   assign lim_x  = {1'b0, rx_fix} + {1'b0, soft_ff};
   assign lim_y  = {1'b0, ry_fix} + {1'b0, soft_ff};
   assign far    = (ax > {{(ABS_W-9){1'b0}}, lim_x}) || (ay > {{(ABS_W-9){1'b0}}, lim_y});

   always_comb begin
      s1_side_in             = '0;
      s1_side_in.far         = far;
      s1_side_in.rmax        = (rx_fix > ry_fix) ? rx_fix : ry_fix;
      s1_side_in.opacity     = req_data.opacity;
      s1_side_in.color_red   = req_data.color_red;
      s1_side_in.color_green = req_data.color_green;
      s1_side_in.color_blue  = req_data.color_blue;
      s1_side_in.current_rgb = req_data.current_rgb;
   end

   logic         s1_valid_ff;
   logic [8:0]   s1_ax_ff, s1_ay_ff;
   logic [7:0]   s1_rx_ff, s1_ry_ff;
   sep_side_type s1_side_ff;

   // far pixels get zero offsets so the divider bounds hold; alpha is 0 anyway
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_ax_ff   <= far ? 9'd0 : ax[8:0];
      s1_ay_ff   <= far ? 9'd0 : ay[8:0];
      s1_rx_ff   <= rx_fix;
      s1_ry_ff   <= ry_fix;
      s1_side_ff <= s1_side_in;
   end

   // ------------------------------------------------------------------
   // S2: squares
   // ------------------------------------------------------------------
   logic         s2_valid_ff;
   logic [17:0]  s2_ax2_ff, s2_ay2_ff;
   logic [15:0]  s2_rx2_ff, s2_ry2_ff;
   sep_side_type s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_ax2_ff  <= s1_ax_ff * s1_ax_ff;
      s2_ay2_ff  <= s1_ay_ff * s1_ay_ff;
      s2_rx2_ff  <= s1_rx_ff * s1_rx_ff;
      s2_ry2_ff  <= s1_ry_ff * s1_ry_ff;
      s2_side_ff <= s1_side_ff;
   end

   // ------------------------------------------------------------------
   // S3: cross products
   // ------------------------------------------------------------------
   logic                  s3_valid_ff;
   logic [33:0]           s3_p1_ff, s3_p2_ff;
   logic [DIV1_DEN_W-1:0] s3_den_ff;
   sep_side_type          s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_p1_ff   <= s2_ax2_ff * s2_ry2_ff;
      s3_p2_ff   <= s2_ay2_ff * s2_rx2_ff;
      s3_den_ff  <= s2_rx2_ff * s2_ry2_ff;
      s3_side_ff <= s2_side_ff;
   end

   // ------------------------------------------------------------------
   // S4: numerator and the exact inside test num <= den
   // ------------------------------------------------------------------
   logic [NUM_W-1:0] num_sum;
   logic             s4_valid_ff;
   logic [NUM_W-1:0] s4_num_ff;
   logic [DIV1_DEN_W-1:0] s4_den_ff;
   sep_side_type     s4_side_ff;
   sep_side_type     s4_side_in;

   assign num_sum = {1'b0, s3_p1_ff} + {1'b0, s3_p2_ff};

   always_comb begin
      s4_side_in         = s3_side_ff;
      s4_side_in.in_core = !s3_side_ff.far &&
                           (num_sum <= {{(NUM_W-DIV1_DEN_W){1'b0}}, s3_den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_num_ff  <= num_sum;
      s4_den_ff  <= s3_den_ff;
      s4_side_ff <= s4_side_in;
   end

   // ------------------------------------------------------------------
   // d^2 in Q.28 = (num << 28) / den, then d in Q.14 = isqrt(d^2)
   // ------------------------------------------------------------------
   logic                   q_valid;
   logic [DIV1_QUOT_W-1:0] q_val;
   sep_side_type           q_side;
   logic                   d_valid;
   logic [ROOT_W-1:0]      d_val;
   sep_side_type           d_side;

   sep_div_pipe #(
      .DEN_W  (DIV1_DEN_W),
      .QUOT_W (DIV1_QUOT_W)
   ) u_dist_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s4_valid_ff),
      .in_dividend ({{PAD1_W{1'b0}}, s4_num_ff, {FRAC_SHIFT{1'b0}}}),
      .in_divisor  (s4_den_ff),
      .in_side     (s4_side_ff),
      .out_valid   (q_valid),
      .out_quot    (q_val),
      .out_side    (q_side)
   );

   sep_sqrt_pipe #(
      .RW (ROOT_W)
   ) u_dist_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_valid),
      .in_radicand (q_val),
      .in_side     (q_side),
      .out_valid   (d_valid),
      .out_root    (d_val),
      .out_side    (d_side)
   );

   // ------------------------------------------------------------------
   // S5: inside alpha = 1 - 0.12 d; rim product (d - 1) * max(r)
   // ------------------------------------------------------------------
   logic [14:0]        dd;
   logic [27:0]        inner_prod;
   logic [ROOT_W-1:0]  over;
   logic               d_gt_one;

   assign d_gt_one   = d_val > {{(ROOT_W-15){1'b0}}, ONE_Q14};
   assign dd         = d_gt_one ? ONE_Q14 : d_val[14:0];
   assign inner_prod = INNER_SLOPE * dd;
   assign over       = d_gt_one ? (d_val - {{(ROOT_W-15){1'b0}}, ONE_Q14}) : '0;

   logic         s5_valid_ff;
   logic [16:0]  s5_alpha_ff;
   logic [30:0]  s5_prod_ff;
   sep_side_type s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= d_valid;
      end
      s5_alpha_ff <= ONE_Q16 - {3'b000, inner_prod[27:14]};
      s5_prod_ff  <= over * d_side.rmax;
      s5_side_ff  <= d_side;
   end

   // ------------------------------------------------------------------
   // S6: rim selection; t >= 1.0 (prod >= soft << 14) means outside
   // ------------------------------------------------------------------
   logic         rim_ok;
   sep_side_type s6_side_in;

   assign rim_ok = !s5_side_ff.in_core && !s5_side_ff.far && (soft_ff != 8'd0) &&
                   (s5_prod_ff < {9'd0, soft_ff, 14'd0});

   always_comb begin
      s6_side_in       = s5_side_ff;
      s6_side_in.rim   = rim_ok;
      s6_side_in.alpha = s5_side_ff.in_core ? s5_alpha_ff : 17'd0;
   end

   logic                               s6_valid_ff;
   logic [DIV2_DEN_W+DIV2_QUOT_W-1:0]  s6_dvd_ff;
   sep_side_type                       s6_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      s6_dvd_ff  <= rim_ok ? s5_prod_ff[DIV2_DEN_W+DIV2_QUOT_W-1:0] : '0;
      s6_side_ff <= s6_side_in;
   end

   logic                   t_valid;
   logic [DIV2_QUOT_W-1:0] t_val;
   sep_side_type           t_side;

   sep_div_pipe #(
      .DEN_W  (DIV2_DEN_W),
      .QUOT_W (DIV2_QUOT_W)
   ) u_rim_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s6_valid_ff),
      .in_dividend (s6_dvd_ff),
      .in_divisor  (soft_ff),
      .in_side     (s6_side_ff),
      .out_valid   (t_valid),
      .out_quot    (t_val),
      .out_side    (t_side)
   );

   // ------------------------------------------------------------------
   // S7..S9: smoothstep in Q.14, rim alpha = 0.9 (1 - sm)
   // ------------------------------------------------------------------
   logic [27:0]  t_sq;
   assign t_sq = t_val * t_val;

   logic         s7_valid_ff;
   logic [13:0]  s7_t2_ff;
   logic [15:0]  s7_w_ff;
   sep_side_type s7_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= t_valid;
      end
      s7_t2_ff   <= t_sq[27:14];
      s7_w_ff    <= SMOOTH_3 - {1'b0, t_val, 1'b0};
      s7_side_ff <= t_side;
   end

   logic [29:0]  sm_prod;
   assign sm_prod = s7_t2_ff * s7_w_ff;

   logic         s8_valid_ff;
   logic [14:0]  s8_sm_ff;
   sep_side_type s8_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else begin
         s8_valid_ff <= s7_valid_ff;
      end
      s8_sm_ff   <= (sm_prod[29:14] > {1'b0, ONE_Q14}) ? ONE_Q14 : sm_prod[28:14];
      s8_side_ff <= s7_side_ff;
   end

   logic [30:0]  rim_prod;
   assign rim_prod = RIM_PEAK * (ONE_Q14 - s8_sm_ff);

   logic         s9_valid_ff;
   logic [16:0]  s9_shape_ff;
   sep_side_type s9_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else begin
         s9_valid_ff <= s8_valid_ff;
      end
      s9_shape_ff <= s8_side_ff.rim ? rim_prod[30:14] : s8_side_ff.alpha;
      s9_side_ff  <= s8_side_ff;
   end

   // ------------------------------------------------------------------
   // S10..S11: alpha * opacity * fade >> 16, clamp to 1.0
   // ------------------------------------------------------------------
   logic         s10_valid_ff;
   logic [25:0]  s10_a1_ff;
   sep_side_type s10_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else begin
         s10_valid_ff <= s9_valid_ff;
      end
      s10_a1_ff   <= s9_shape_ff * s9_side_ff.opacity;
      s10_side_ff <= s9_side_ff;
   end

   logic [34:0]  a2_prod;
   assign a2_prod = s10_a1_ff * fade_ff;

   logic         s11_valid_ff;
   logic [16:0]  s11_alpha_ff;
   sep_side_type s11_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else begin
         s11_valid_ff <= s10_valid_ff;
      end
      s11_alpha_ff <= (a2_prod[34:16] > {2'b00, ONE_Q16}) ? ONE_Q16 : a2_prod[32:16];
      s11_side_ff  <= s10_side_ff;
   end

   // ------------------------------------------------------------------
   // S12: alpha * color per channel, threshold
   // ------------------------------------------------------------------
   logic         s12_valid_ff;
   logic         s12_write_ff;
   logic [25:0]  s12_pr_ff, s12_pg_ff, s12_pb_ff;
   logic [23:0]  s12_cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s12_valid_ff <= 1'b0;
      end else begin
         s12_valid_ff <= s11_valid_ff;
      end
      s12_write_ff <= s11_alpha_ff > ALPHA_MIN;
      s12_pr_ff    <= s11_alpha_ff * s11_side_ff.color_red;
      s12_pg_ff    <= s11_alpha_ff * s11_side_ff.color_green;
      s12_pb_ff    <= s11_alpha_ff * s11_side_ff.color_blue;
      s12_cur_ff   <= s11_side_ff.current_rgb;
   end

   // ------------------------------------------------------------------
   // S13: (p * 255) >> 24, saturating add, output register
   // ------------------------------------------------------------------
   logic [33:0] x255_r, x255_g, x255_b;
   logic [10:0] sum_r, sum_g, sum_b;
   logic [7:0]  sat_r, sat_g, sat_b;

   assign x255_r = {s12_pr_ff, 8'd0} - {8'd0, s12_pr_ff};
   assign x255_g = {s12_pg_ff, 8'd0} - {8'd0, s12_pg_ff};
   assign x255_b = {s12_pb_ff, 8'd0} - {8'd0, s12_pb_ff};
   assign sum_r  = {3'b000, s12_cur_ff[23:16]} + {1'b0, x255_r[33:24]};
   assign sum_g  = {3'b000, s12_cur_ff[15:8]}  + {1'b0, x255_g[33:24]};
   assign sum_b  = {3'b000, s12_cur_ff[7:0]}   + {1'b0, x255_b[33:24]};
   assign sat_r  = (sum_r > 11'd255) ? 8'd255 : sum_r[7:0];
   assign sat_g  = (sum_g > 11'd255) ? 8'd255 : sum_g[7:0];
   assign sat_b  = (sum_b > 11'd255) ? 8'd255 : sum_b[7:0];

   logic        rsp_valid_ff;
   sep_rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s12_valid_ff;
      end
      rsp_data_ff.new_rgb       <= s12_write_ff ? {sat_r, sat_g, sat_b} : s12_cur_ff;
      rsp_data_ff.pixel_written <= s12_write_ff;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `SEP_ASSERT_IMPL(a_fixed_latency, rsp_strobe, $past(accept, LATENCY), "result without item")
   `SEP_ASSERT_IMPL(a_unwritten_keeps, rsp_strobe && !rsp_data.pixel_written,
      rsp_data.new_rgb == $past(req_data.current_rgb, LATENCY), "unwritten pixel changed")
   `SEP_ASSERT_IMPL(a_alpha_clamped, s11_valid_ff, s11_alpha_ff <= ONE_Q16, "alpha over 1.0")
   `SEP_ASSERT_NEXT(a_write_flag, s12_valid_ff && s12_write_ff,
      rsp_strobe && rsp_data.pixel_written, "write flag lost")

endmodule

`default_nettype wire
